@@ src/tcc_pkg.sv @@
// Package for the triangle circumcenter core: beat payload types and fixed constants.
// No dependencies; used by tcc_div and triangle_circumcenter_core.
package tcc_pkg;

   localparam int TCC_FIELD_BITS = 16;
   localparam int TCC_OUT_BITS   = 32;
   localparam int TCC_QBITS      = 32;
   localparam int TCC_DIV_LAT    = TCC_QBITS + 3;

   typedef struct packed {
      logic signed [TCC_FIELD_BITS-1:0] ax;
      logic signed [TCC_FIELD_BITS-1:0] ay;
      logic signed [TCC_FIELD_BITS-1:0] bx;
      logic signed [TCC_FIELD_BITS-1:0] by_coord;
      logic signed [TCC_FIELD_BITS-1:0] cx;
      logic signed [TCC_FIELD_BITS-1:0] cy;
   } tcc_req_type;

   typedef struct packed {
      logic signed [TCC_OUT_BITS-1:0] center_x;
      logic signed [TCC_OUT_BITS-1:0] center_y;
      logic                           degenerate;
      logic                           saturated;
   } tcc_rsp_type;

endpackage

@@ src/tcc_div.sv @@
// Pipelined rounding divider: one restoring quotient bit per stage, saturated to 32 bits.
// Depends on tcc_pkg for the quotient width.
module tcc_div
   import tcc_pkg::*;
#(
   parameter int NUM_BITS = 51,
   parameter int DEN_BITS = 35,
   parameter int SHIFT    = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [NUM_BITS-1:0] num,
   input  logic signed [DEN_BITS-1:0] den,
   output logic                       out_valid,
   output logic [TCC_QBITS-1:0]       quo,
   output logic                       sat
);

   localparam int NB = NUM_BITS + SHIFT + 1;
   localparam int WB = ((NB > DEN_BITS + TCC_QBITS + 1) ? NB : DEN_BITS + TCC_QBITS + 1) + 1;
   localparam int RW = DEN_BITS;
   localparam int NS = TCC_QBITS;

   // stage A: magnitudes, rounding offset
   logic [WB-1:0] nmag_in, n_in, n_ff;
   logic [RW-1:0] dmag_in, den_in, dena_ff;
   logic          nega_in, nega_ff, va_ff;

   always_comb begin
      nmag_in = num[NUM_BITS-1] ? WB'(-WB'(num)) : WB'(num);
      dmag_in = den[DEN_BITS-1] ? RW'(-den) : RW'(den);
      n_in    = (nmag_in << SHIFT) + WB'(dmag_in);
      den_in  = dmag_in << 1;
      nega_in = num[NUM_BITS-1] ^ den[DEN_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
      n_ff    <= n_in;
      dena_ff <= den_in;
      nega_ff <= nega_in;
   end

   // stage B and bit stages
   logic [RW-1:0]    rem_ff [0:NS-1];
   logic [NS-1:0]    low_ff [0:NS-1];
   logic [NS-1:0]    q_ff   [0:NS];
   logic [RW-1:0]    dv_ff  [0:NS-1];
   logic             ng_ff  [0:NS];
   logic             ov_ff  [0:NS];
   logic             v_ff   [0:NS];
   logic             ovf_in;

   assign ovf_in = n_ff >= (WB'(dena_ff) << NS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= va_ff;
      end
      rem_ff[0] <= RW'(n_ff >> NS);
      low_ff[0] <= n_ff[NS-1:0];
      q_ff[0]   <= '0;
      dv_ff[0]  <= dena_ff;
      ng_ff[0]  <= nega_ff;
      ov_ff[0]  <= ovf_in;
   end

   for (genvar k = 0; k < NS; k++) begin : g_step
      logic [RW:0]   r2_in;
      logic          ge_in;
      logic [RW-1:0] rem_in;

      always_comb begin
         r2_in  = {rem_ff[k], low_ff[k][NS-1]};
         ge_in  = r2_in >= {1'b0, dv_ff[k]};
         rem_in = ge_in ? RW'(r2_in - {1'b0, dv_ff[k]}) : RW'(r2_in);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
         q_ff[k+1]   <= {q_ff[k][NS-2:0], ge_in};
         ng_ff[k+1]  <= ng_ff[k];
         ov_ff[k+1]  <= ov_ff[k];
      end

      if (k < NS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= rem_in;
            low_ff[k+1] <= low_ff[k] << 1;
            dv_ff[k+1]  <= dv_ff[k];
         end
      end
   end

   // clamp and sign
   logic [NS-1:0] limit_in, mag_in, quo_in, quo_ff;
   logic          sat_in, sat_ff, vo_ff;

   always_comb begin
      limit_in = ng_ff[NS] ? {1'b1, {(NS-1){1'b0}}} : {1'b0, {(NS-1){1'b1}}};
      sat_in   = ov_ff[NS] || (q_ff[NS] > limit_in);
      mag_in   = sat_in ? limit_in : q_ff[NS];
      quo_in   = ng_ff[NS] ? NS'(-mag_in) : mag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= v_ff[NS];
      end
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign out_valid = vo_ff;
   assign quo       = quo_ff;
   assign sat       = sat_ff;

endmodule

@@ src/triangle_circumcenter_core.sv @@
// Top level of the triangle circumcenter core: arithmetic front end and two dividers.
// Depends on tcc_pkg and tcc_div.
//
// Usage: drive a triangle on req and raise start; the beat is taken at any edge with
// start high and busy low. busy stays low, so one triangle may enter every cycle.
// Each triangle gives one result beat on rsp, marked by rsp_strobe for exactly one
// cycle. The beat passes the input register, then stages of squares, products and
// sums, then a divider per axis (one quotient bit per stage, 32 stages, plus setup and
// clamp), then the output register. Throughput is one beat per cycle.
// Coordinates are signed with FRAC_BITS fraction bits; centers are signed Q16.16,
// rounded to nearest, ties away from zero, clamped with saturated set. Collinear
// vertices give degenerate set and zero centers.
// Reset clears all valid bits; beats in flight are dropped. The receiver cannot stall:
// a result is presented once and must be taken in that cycle.
module triangle_circumcenter_core
   import tcc_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  tcc_req_type req,
   output logic        rsp_strobe,
   output tcc_rsp_type rsp
);

   localparam int C     = COORD_BITS;
   localparam int FW    = C + 1;
   localparam int SW    = 2 * C;
   localparam int LW    = 2 * C + 1;
   localparam int DW    = 2 * C + 3;
   localparam int NW    = 3 * C + 3;
   localparam int SHIFT = 16 - FRAC_BITS;
   localparam int LAT   = TCC_DIV_LAT + 6;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // input: take low COORD_BITS bits, or sign-extend narrow fields
   logic signed [C-1:0] ax_in, ay_in, bx_in, by_in, cx_in, cy_in;
   if (C <= TCC_FIELD_BITS) begin : g_trunc
      assign ax_in = req.ax[C-1:0];
      assign ay_in = req.ay[C-1:0];
      assign bx_in = req.bx[C-1:0];
      assign by_in = req.by_coord[C-1:0];
      assign cx_in = req.cx[C-1:0];
      assign cy_in = req.cy[C-1:0];
   end else begin : g_ext
      assign ax_in = C'(req.ax);
      assign ay_in = C'(req.ay);
      assign bx_in = C'(req.bx);
      assign by_in = C'(req.by_coord);
      assign cx_in = C'(req.cx);
      assign cy_in = C'(req.cy);
   end

   logic signed [C-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic                v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
      end
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
   end

   // stage 1: differences and squares
   logic signed [FW-1:0] dbc_ff, dca_ff, dab_ff, ebc_ff, eca_ff, eab_ff;
   logic signed [SW-1:0] sax_ff, say_ff, sbx_ff, sby_ff, scx_ff, scy_ff;
   logic signed [C-1:0]  ax1_ff, bx1_ff, cx1_ff;
   logic                 v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      dbc_ff <= FW'(by_ff) - FW'(cy_ff);
      dca_ff <= FW'(cy_ff) - FW'(ay_ff);
      dab_ff <= FW'(ay_ff) - FW'(by_ff);
      ebc_ff <= FW'(bx_ff) - FW'(cx_ff);
      eca_ff <= FW'(cx_ff) - FW'(ax_ff);
      eab_ff <= FW'(ax_ff) - FW'(bx_ff);
      sax_ff <= SW'(ax_ff) * SW'(ax_ff);
      say_ff <= SW'(ay_ff) * SW'(ay_ff);
      sbx_ff <= SW'(bx_ff) * SW'(bx_ff);
      sby_ff <= SW'(by_ff) * SW'(by_ff);
      scx_ff <= SW'(cx_ff) * SW'(cx_ff);
      scy_ff <= SW'(cy_ff) * SW'(cy_ff);
      ax1_ff <= ax_ff;
      bx1_ff <= bx_ff;
      cx1_ff <= cx_ff;
   end

   // stage 2: squared lengths, determinant terms
   logic signed [LW-1:0] la_ff, lb_ff, lc_ff;
   logic signed [DW-1:0] pd0_ff, pd1_ff, pd2_ff;
   logic signed [FW-1:0] dbc2_ff, dca2_ff, dab2_ff, ebc2_ff, eca2_ff, eab2_ff;
   logic                 v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      la_ff   <= LW'(sax_ff) + LW'(say_ff);
      lb_ff   <= LW'(sbx_ff) + LW'(sby_ff);
      lc_ff   <= LW'(scx_ff) + LW'(scy_ff);
      pd0_ff  <= DW'(ax1_ff) * DW'(dbc_ff);
      pd1_ff  <= DW'(bx1_ff) * DW'(dca_ff);
      pd2_ff  <= DW'(cx1_ff) * DW'(dab_ff);
      dbc2_ff <= dbc_ff;
      dca2_ff <= dca_ff;
      dab2_ff <= dab_ff;
      ebc2_ff <= ebc_ff;
      eca2_ff <= eca_ff;
      eab2_ff <= eab_ff;
   end

   // stage 3: determinant, numerator terms
   logic signed [DW-1:0] d3_ff;
   logic signed [NW-1:0] px0_ff, px1_ff, px2_ff, py0_ff, py1_ff, py2_ff;
   logic                 v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      d3_ff  <= pd0_ff + pd1_ff + pd2_ff;
      px0_ff <= NW'(la_ff) * NW'(dbc2_ff);
      px1_ff <= NW'(lb_ff) * NW'(dca2_ff);
      px2_ff <= NW'(lc_ff) * NW'(dab2_ff);
      py0_ff <= NW'(la_ff) * NW'(ebc2_ff);
      py1_ff <= NW'(lb_ff) * NW'(eca2_ff);
      py2_ff <= NW'(lc_ff) * NW'(eab2_ff);
   end

   // stage 4: numerators, denominators, degenerate flag
   logic signed [NW-1:0] nx_ff, ny_ff;
   logic signed [DW-1:0] dp_ff, dn_ff;
   logic                 deg4_ff, v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      nx_ff   <= px0_ff + px1_ff + px2_ff;
      ny_ff   <= py0_ff + py1_ff + py2_ff;
      dp_ff   <= d3_ff;
      dn_ff   <= -d3_ff;
      deg4_ff <= (d3_ff == '0);
   end

   logic                 vx, vy, satx, saty;
   logic [TCC_QBITS-1:0] qx, qy;

   tcc_div #(.NUM_BITS(NW), .DEN_BITS(DW), .SHIFT(SHIFT)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .num       (nx_ff),
      .den       (dp_ff),
      .out_valid (vx),
      .quo       (qx),
      .sat       (satx)
   );

   tcc_div #(.NUM_BITS(NW), .DEN_BITS(DW), .SHIFT(SHIFT)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .num       (ny_ff),
      .den       (dn_ff),
      .out_valid (vy),
      .quo       (qy),
      .sat       (saty)
   );

   // carry the degenerate flag alongside the dividers
   logic [TCC_DIV_LAT-1:0] deg_ff;

   always_ff @(posedge clock) begin
      deg_ff <= {deg_ff[TCC_DIV_LAT-2:0], deg4_ff};
   end

   // output register
   tcc_rsp_type rsp_in, rsp_ff;
   logic        deg_o;
   logic        strobe_ff;

   always_comb begin
      deg_o              = deg_ff[TCC_DIV_LAT-1];
      rsp_in.degenerate  = deg_o;
      rsp_in.center_x    = deg_o ? '0 : $signed(qx);
      rsp_in.center_y    = deg_o ? '0 : $signed(qy);
      rsp_in.saturated   = !deg_o && (satx || saty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vx;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_strobe)
      else $error("result beat missing after pipeline latency");

   a_lanes : assert property (@(posedge clock) disable iff (reset)
      vx == vy)
      else $error("divider lanes out of step");

   a_degenerate : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.degenerate |->
         rsp.center_x == '0 && rsp.center_y == '0 && !rsp.saturated)
      else $error("degenerate beat carries data");

   a_clamp : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.saturated |->
         rsp.center_x == 32'sh7FFFFFFF || rsp.center_x == 32'sh80000000 ||
         rsp.center_y == 32'sh7FFFFFFF || rsp.center_y == 32'sh80000000)
      else $error("saturated beat without clamped center");

endmodule
